/* design/rde_pkg.sv */
package rde_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;

    // magnitude bits and digit lanes (radix 2 needs all 32)
    localparam int MAG_W  = 32;
    localparam int DIGITS = 32;
    localparam int PTR_W  = 5;
    localparam int BIT_W  = 5;

    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 8'd2;

    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_LOW   = 8'd32;
    localparam logic [7:0] CH_HIGH  = 8'd126;

    typedef struct packed {
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CONV,
        ST_SCAN,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic alpha_ok;
        logic conv_done;
        logic lead_nz;
        logic ptr_zero;
        logic neg;
        logic out_free;
    } t_dp_stat;

endpackage

/* design/rde_stream_if.sv */
interface rde_stream_if #(
    parameter type t_word = logic
) ();
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/rde_ctrl.sv */
module rde_ctrl import rde_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_stat.alpha_ok ? ST_CONV : ST_IDLE;
            end
            ST_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_stat.conv_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // skip leading zero digits, keep at least one
                if (i_stat.lead_nz || i_stat.ptr_zero) begin
                    n_state = i_stat.neg ? ST_SIGN : ST_EMIT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            ST_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_stat.ptr_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == ST_CHECK)
        else $error("accepted word did not enter alphabet check");

    a_bad_alpha_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CHECK && !i_stat.alpha_ok |=> r_state == ST_IDLE)
        else $error("invalid alphabet did not drop the word");

    a_emit_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_sign || o_cmd.emit_digit) |-> i_stat.out_free)
        else $error("emit while output register busy");

endmodule

/* design/rde_dp.sv */
module rde_dp import rde_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_word              i_in_word,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out_word             o_out_word,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int DIG_W = (MAX_SYMBOLS > 2) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int RAD_W = DIG_W + 1;

    // configuration
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_sym [MAX_SYMBOLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                r_sym[k] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYMBOL_COUNT: begin
                    r_count <= i_cfg_data[CNT_W-1:0];
                end
                CFG_SYMBOLS_LOW: begin
                    for (int k = 0; k < MAX_SYMBOLS && k < 8; k++) begin
                        r_sym[k] <= i_cfg_data[8*k +: 8];
                    end
                end
                CFG_SYMBOLS_HIGH: begin
                    for (int k = 8; k < MAX_SYMBOLS; k++) begin
                        r_sym[k] <= i_cfg_data[8*(k-8) +: 8];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // alphabet check, registered; the user keeps config quiet before use, the block does not enforce it
    logic r_alpha_ok;
    logic n_alpha_ok;

    always_comb begin
        n_alpha_ok = (r_count >= CNT_W'(2)) && (r_count <= CNT_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (CNT_W'(i) < r_count) begin
                if (r_sym[i] == CH_PLUS || r_sym[i] == CH_MINUS ||
                    r_sym[i] < CH_LOW || r_sym[i] > CH_HIGH) begin
                    n_alpha_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if (CNT_W'(j) < r_count && r_sym[i] == r_sym[j]) begin
                        n_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_ok <= 1'b0;
        end else begin
            r_alpha_ok <= n_alpha_ok;
        end
    end

    // bit-serial radix conversion: each cycle all digit lanes double and
    // take the next magnitude bit; lane carries resolved by one wide add
    logic [RAD_W-1:0] radix;
    logic [MAG_W-1:0] r_mag;
    logic             r_neg;
    logic [BIT_W-1:0] r_bit;
    logic [PTR_W-1:0] r_ptr;
    logic [DIG_W-1:0] r_dig [DIGITS];

    logic [DIGITS-1:0] gen;
    logic [DIGITS-1:0] prop;
    logic [DIGITS-1:0] grp;
    logic [DIGITS-1:0] csum;
    logic [DIGITS-1:0] cin;
    logic [DIGITS-1:0] cout;
    logic [DIG_W-1:0]  n_dig [DIGITS];

    assign radix = r_count[RAD_W-1:0];

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            gen[i]  = {r_dig[i], 1'b0} >= radix;
            prop[i] = !gen[i] && ({r_dig[i], 1'b1} >= radix);
        end
        grp  = gen | prop;
        csum = grp + gen + DIGITS'(r_mag[MAG_W-1]);
        cin  = csum ^ grp ^ gen;
        for (int i = 0; i < DIGITS; i++) begin
            logic [RAD_W-1:0] t;
            logic [RAD_W-1:0] d;
            t       = {r_dig[i], cin[i]};
            cout[i] = gen[i] | (prop[i] & cin[i]);
            d       = cout[i] ? (t - radix) : t;
            n_dig[i] = d[DIG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg <= i_in_word.value[31];
            r_mag <= i_in_word.value[31] ? (MAG_W'(0) - MAG_W'(i_in_word.value))
                                         : MAG_W'(i_in_word.value);
            r_bit <= '0;
            r_ptr <= PTR_W'(DIGITS - 1);
            for (int i = 0; i < DIGITS; i++) begin
                r_dig[i] <= '0;
            end
        end else begin
            if (i_cmd.conv_step) begin
                r_mag <= {r_mag[MAG_W-2:0], 1'b0};
                r_bit <= r_bit + BIT_W'(1);
                for (int i = 0; i < DIGITS; i++) begin
                    r_dig[i] <= n_dig[i];
                end
            end
            if (i_cmd.scan_step || i_cmd.emit_digit) begin
                r_ptr <= r_ptr - PTR_W'(1);
            end
        end
    end

    // output register
    logic      r_out_valid;
    t_out_word r_out;
    logic      out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out.out_char <= CH_MINUS;
            r_out.last     <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out.out_char <= r_sym[r_dig[r_ptr]];
            r_out.last     <= (r_ptr == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign o_stat.alpha_ok  = r_alpha_ok;
    assign o_stat.conv_done = (r_bit == BIT_W'(MAG_W - 1));
    assign o_stat.lead_nz   = (r_dig[r_ptr] != '0);
    assign o_stat.ptr_zero  = (r_ptr == '0);
    assign o_stat.neg       = r_neg;
    assign o_stat.out_free  = out_free;

    a_no_top_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.conv_step |-> !cout[DIGITS-1])
        else $error("conversion overflowed the top digit lane");

    a_digit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit |-> RAD_W'(r_dig[r_ptr]) < radix)
        else $error("emitted digit not below radix");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit && r_ptr == '0 |=> r_out_valid && r_out.last)
        else $error("final digit not flagged last");

endmodule

/* design/radix_digit_emitter.sv */
// Converts a signed 32-bit value to text in the radix set by the configured
// alphabet (symbol_count symbols, symbol 0 is digit zero), one character per
// output word, most significant first, a '-' first for negative values, and
// last set on the final character. An item passes through acceptance, the
// alphabet check, bit-serial radix conversion (one magnitude bit per cycle
// into all digit lanes), a scan past leading zero digits, then the sign and
// digits, each sent only when the output register is free. A new value is
// taken only after the last character of the previous one has been issued.
// A value under an invalid alphabet produces nothing; the input is freed
// after the check. Write configuration only while no value is in flight.
module radix_digit_emitter import rde_pkg::*; #(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rde_stream_if.sink            i_value_s,
    rde_stream_if.source          o_char_s
);

    t_dp_cmd   cmd;
    t_dp_stat  stat;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_word;

    rde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_value_s.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rde_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_value_s.data),
        .i_out_ready (o_char_s.ready),
        .o_out_valid (out_valid),
        .o_out_word  (out_word),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    assign i_value_s.ready = in_ready;
    assign o_char_s.valid  = out_valid;
    assign o_char_s.data   = out_word;

endmodule

/* tb/testbench.sv */
module testbench;
    import rde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hFC;

    localparam logic [63:0] DEC_LO = 64'h3736_3534_3332_3130;
    localparam logic [63:0] DEC_HI = 64'h0000_0000_0000_3938;
    localparam logic [63:0] HEX_HI = 64'h4645_4443_4241_3938;
    // only the first two bytes count; the rest hold '+', '-' and unprintables
    localparam logic [63:0] BIN_LO = 64'hFF00_1F7F_2B2D_3130;

    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 80;

    typedef enum int {
        FLAW_COUNT,
        FLAW_PLUS,
        FLAW_MINUS,
        FLAW_LOW_CHAR,
        FLAW_HIGH_CHAR,
        FLAW_DUP
    } t_flaw;

    logic                  i_clk = 1'b0;
    logic                  rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rde_stream_if #(.t_word(t_in_word))  value_if ();
    rde_stream_if #(.t_word(t_out_word)) char_if ();

    radix_digit_emitter #(.MAX_SYMBOLS(MAX_SYMBOLS_DEF)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_value_s   (value_if.sink),
        .o_char_s    (char_if.source)
    );

    // mirror of the configuration registers
    logic [CNT_W-1:0] sym_count;
    logic [63:0]      sym_lo;
    logic [63:0]      sym_hi;

    logic [31:0] value_q [$];
    t_out_word   text_q [$];
    t_in_word    next_word;
    logic        value_taken;

    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_go;
    bit  hold_on;
    int  err_cnt;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    // expected characters of one value under the current alphabet
    function automatic void predict_text(input logic [31:0] v);
        logic [127:0] alpha;
        logic [7:0]   sym [16];
        logic [31:0]  mag;
        logic [31:0]  radix;
        int           digs [$];
        bit           ok;
        t_out_word    w;
        alpha = {sym_hi, sym_lo};
        radix = 32'(sym_count);
        ok = (sym_count >= 2) && (sym_count <= MAX_SYMBOLS_DEF);
        for (int i = 0; i < 16; i++) begin
            sym[i] = alpha[8*i +: 8];
        end
        for (int i = 0; i < 16; i++) begin
            if (ok && i < sym_count) begin
                if (sym[i] == CH_PLUS || sym[i] == CH_MINUS || sym[i] < CH_LOW
                    || sym[i] > CH_HIGH) begin
                    ok = 0;
                end
                for (int j = i + 1; j < 16; j++) begin
                    if (j < sym_count && sym[j] == sym[i]) begin
                        ok = 0;
                    end
                end
            end
        end
        if (!ok) begin
            return;
        end
        mag = v[31] ? (32'd0 - v) : v;
        do begin
            digs.push_front(int'(mag % radix));
            mag = mag / radix;
        end while (mag != 0);
        if (v[31]) begin
            w.out_char = CH_MINUS;
            w.last = 1'b0;
            text_q.push_back(w);
        end
        foreach (digs[k]) begin
            w.out_char = sym[digs[k]];
            w.last = (k == digs.size() - 1);
            text_q.push_back(w);
        end
    endfunction

    function automatic logic [31:0] pick_value(input int radix);
        logic [31:0] p;
        int r;
        r = (radix < 2) ? 2 : radix;
        p = 32'd1;
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(r * r);
            3: return 32'd0 - $urandom_range(r * 2);
            4: begin
                repeat ($urandom_range(1, 8)) p = p * r;
                p = p - $urandom_range(1);
                return $urandom_range(1) ? p : (32'd0 - p);
            end
            default: return $urandom();
        endcase
    endfunction

    // sender: hold the word until taken, then offer the next or idle
    always @(negedge i_clk) begin
        if (!rst_n) begin
            value_if.valid <= 1'b0;
        end else if (!value_if.valid || value_taken) begin
            if (value_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_word.value = value_q.pop_front();
                value_if.data <= next_word;
                value_if.valid <= 1'b1;
            end else begin
                value_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!rst_n || hold_on) begin
            char_if.ready <= 1'b0;
        end else begin
            char_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on = 1'b0;
    end

    always @(posedge i_clk) begin
        value_taken <= rst_n && value_if.valid && value_if.ready;
        if (rst_n && value_if.valid && value_if.ready) begin
            predict_text(value_if.data.value);
        end
    end

    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (rst_n && char_if.valid && char_if.ready) begin
            if (text_q.size() == 0) begin
                note_error($sformatf("unexpected char %h last %b",
                                     char_if.data.out_char, char_if.data.last));
            end else begin
                exp_word = text_q.pop_front();
                if (char_if.data.out_char !== exp_word.out_char
                    || char_if.data.last !== exp_word.last) begin
                    note_error($sformatf("char exp %h/%b got %h/%b",
                                         exp_word.out_char, exp_word.last,
                                         char_if.data.out_char, char_if.data.last));
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SYMBOL_COUNT: sym_count = data[CNT_W-1:0];
            CFG_SYMBOLS_LOW:  sym_lo = data;
            CFG_SYMBOLS_HIGH: sym_hi = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_count(input logic [CNT_W-1:0] cnt);
        logic [63:0] d;
        d = {$urandom, $urandom};
        d[CNT_W-1:0] = cnt;
        write_reg(CFG_SYMBOL_COUNT, d);
    endtask

    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (value_q.size() != 0 || value_if.valid || text_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // n distinct printable symbols, optionally spoiled in one way
    task automatic load_alphabet(input int n, input bit broken);
        logic [7:0]       pool [$];
        logic [127:0]     alpha;
        logic [CNT_W-1:0] cnt;
        int               pick;
        int               k;
        int               j;
        t_flaw            flaw;
        for (int c = CH_LOW; c <= CH_HIGH; c++) begin
            if (c != CH_PLUS && c != CH_MINUS) begin
                pool.push_back(8'(c));
            end
        end
        alpha = {$urandom, $urandom, $urandom, $urandom};
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(pool.size() - 1);
            alpha[8*i +: 8] = pool[pick];
            pool.delete(pick);
        end
        cnt = CNT_W'(n);
        if (broken) begin
            k = $urandom_range(n - 1);
            flaw = t_flaw'($urandom_range(5));
            case (flaw)
                FLAW_COUNT:     cnt = $urandom_range(1) ? CNT_W'($urandom_range(1))
                                                        : CNT_W'($urandom_range(31, 17));
                FLAW_PLUS:      alpha[8*k +: 8] = CH_PLUS;
                FLAW_MINUS:     alpha[8*k +: 8] = CH_MINUS;
                FLAW_LOW_CHAR:  alpha[8*k +: 8] = 8'($urandom_range(31));
                FLAW_HIGH_CHAR: alpha[8*k +: 8] = 8'($urandom_range(255, 127));
                default: begin
                    j = (k + 1 + $urandom_range(n - 2)) % n;
                    alpha[8*j +: 8] = alpha[8*k +: 8];
                end
            endcase
        end
        write_count(cnt);
        write_reg(CFG_SYMBOLS_LOW, alpha[63:0]);
        write_reg(CFG_SYMBOLS_HIGH, alpha[127:64]);
    endtask

    initial begin
        int n;
        rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        value_if.valid = 1'b0;
        value_if.data = '0;
        char_if.ready = 1'b0;
        value_taken = 1'b0;
        sym_count = '0;
        sym_lo = '0;
        sym_hi = '0;
        hold_go = 0;
        err_cnt = 0;
        tx_idle_pct = 29;
        rx_idle_pct = 83;
        repeat (11) @(negedge i_clk);
        rst_n = 1'b1;
        @(posedge i_clk);

        // reset alphabet is empty: nothing comes out
        value_q.push_back(32'd7);
        wait_idle();

        write_reg(CFG_IDX_SPARE, {$urandom, $urandom});
        write_count(10);
        write_reg(CFG_SYMBOLS_LOW, DEC_LO);
        write_reg(CFG_SYMBOLS_HIGH, DEC_HI);
        value_q = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'd10, 32'hFFFF_FFF6};
        wait_idle();

        write_count(2);
        write_reg(CFG_SYMBOLS_LOW, BIN_LO);
        value_q = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd5};
        wait_idle();

        write_count(16);
        write_reg(CFG_SYMBOLS_LOW, DEC_LO);
        write_reg(CFG_SYMBOLS_HIGH, HEX_HI);
        value_q = '{32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'd255};
        wait_idle();

        // invalid alphabets: count too small, above the cap, bad or repeated symbol
        write_count(1);
        value_q.push_back(32'd3);
        wait_idle();
        write_count(17);
        value_q.push_back(32'd3);
        wait_idle();
        write_count(16);
        write_reg(CFG_SYMBOLS_HIGH, {8'h2B, HEX_HI[55:0]});
        value_q.push_back(32'h1234);
        wait_idle();
        write_reg(CFG_SYMBOLS_HIGH, {8'h2D, HEX_HI[55:0]});
        value_q.push_back(32'h1234);
        wait_idle();
        write_reg(CFG_SYMBOLS_HIGH, {8'h1F, HEX_HI[55:0]});
        value_q.push_back(32'h1234);
        wait_idle();
        write_reg(CFG_SYMBOLS_HIGH, {8'h7F, HEX_HI[55:0]});
        value_q.push_back(32'h1234);
        wait_idle();
        write_reg(CFG_SYMBOLS_HIGH, {8'h00, HEX_HI[55:0]});
        value_q.push_back(32'h1234);
        wait_idle();
        write_reg(CFG_SYMBOLS_HIGH, {8'h30, HEX_HI[55:0]});
        value_q.push_back(32'h1234);
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                tx_idle_pct = 83;
                rx_idle_pct = 29;
            end
            if (ph == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            n = (ph % 4 == 0) ? 2 : (ph % 4 == 1) ? 16 : $urandom_range(2, 16);
            load_alphabet(n, 0);
            if (ph == 8) begin
                hold_go = 1;
            end
            repeat (33) value_q.push_back(pick_value(n));
            wait_idle();
            if (ph % 3 == 2) begin
                load_alphabet($urandom_range(2, 16), 1);
                repeat (5) value_q.push_back(pick_value(n));
                wait_idle();
            end
        end

        if (err_cnt == 0 && text_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* radix_digit_emitter.f */
design/rde_pkg.sv
design/rde_stream_if.sv
design/rde_ctrl.sv
design/rde_dp.sv
design/radix_digit_emitter.sv
tb/testbench.sv
